>>> src/utf8_word_splitter_macros.svh
// Assertion macros used by the word splitter back end
`ifndef UTF8_WORD_SPLITTER_MACROS_SVH
`define UTF8_WORD_SPLITTER_MACROS_SVH

// same-cycle implication
`define UWS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define UWS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/uws_pkg.sv
// Types, constants and byte classes shared by the word splitter modules
package uws_pkg;

  localparam int MAX_WORD_BYTES_DEF = 32;
  localparam int MIN_CHARS_W        = 6;
  localparam logic [MIN_CHARS_W-1:0] MIN_CHARS_RST = 6'd3;
  localparam int EVT_FIFO_DEPTH     = 4;
  localparam int PEND_SLOTS         = 4;

  localparam logic [7:0] BYTE_E2     = 8'he2;
  localparam logic [7:0] BYTE_C2     = 8'hc2;
  localparam logic [7:0] BYTE_80     = 8'h80;
  localparam logic [7:0] BYTE_NBSP   = 8'ha0;
  localparam logic [7:0] BYTE_LSQUO  = 8'h98;
  localparam logic [7:0] BYTE_RSQUO  = 8'h99;
  localparam logic [7:0] BYTE_LDQUO  = 8'h9c;
  localparam logic [7:0] BYTE_RDQUO  = 8'h9d;
  localparam logic [7:0] BYTE_NDASH  = 8'h93;
  localparam logic [7:0] BYTE_MDASH  = 8'h94;
  localparam logic [7:0] BYTE_HELLIP = 8'ha6;
  localparam logic [7:0] BYTE_APOS   = 8'h27;
  localparam logic [7:0] BYTE_HYPHEN = 8'h2d;
  localparam logic [7:0] BYTE_SPACE  = 8'h20;
  localparam logic [7:0] BYTE_LOW_S  = 8'h73;
  localparam logic [7:0] BYTE_UP_S   = 8'h53;
  localparam logic [7:0] CONT_MASK   = 8'hc0;
  localparam logic [7:0] CONT_CODE   = 8'h80;

  typedef enum logic [1:0] {
    HOLD_NONE,
    HOLD_E2,
    HOLD_E2_80,
    HOLD_C2
  } hold_t;

  // one word-building step: append data, or end the current word
  typedef struct packed {
    logic [7:0] data;
    logic       flush;
  } uws_evt_t;

  function automatic logic is_letter(input logic [7:0] b);
    return (b >= 8'h80) || (b inside {[8'h41:8'h5a]}) || (b inside {[8'h61:8'h7a]});
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b inside {[8'h30:8'h39]};
  endfunction

  function automatic logic is_joiner(input logic [7:0] b);
    return (b == BYTE_APOS) || (b == BYTE_HYPHEN);
  endfunction

endpackage

>>> src/uws_front.sv
// Front end: folds UTF-8 punctuation and turns each input beat into word events
module uws_front import uws_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // text_byte
  input  logic       in_tlast,   // end_of_text
  output logic       evt_valid,
  input  logic       evt_ready,
  output uws_evt_t   evt
);

  hold_t       hold_r, hold_nxt;
  logic        started_r, started_nxt;
  uws_evt_t    pend_r [0:PEND_SLOTS-1];
  logic [2:0]  pend_cnt_r, pend_cnt_nxt;
  logic [2:0]  pend_idx_r, pend_idx_nxt;

  logic [7:0]  fb [0:2];
  logic [1:0]  fcnt;
  logic        fresh;
  uws_evt_t    ev [0:PEND_SLOTS-1];
  logic [2:0]  ecnt;
  logic        st;
  logic        pend_empty, pop, last_pop, accept;

  function automatic hold_t fresh_hold(input logic [7:0] b);
    if (b == BYTE_E2) return HOLD_E2;
    if (b == BYTE_C2) return HOLD_C2;
    return HOLD_NONE;
  endfunction

  assign pend_empty = (pend_idx_r == pend_cnt_r);
  assign evt_valid  = !pend_empty;
  assign evt        = pend_r[pend_idx_r[1:0]];
  assign pop        = evt_valid && evt_ready;
  assign last_pop   = pop && ((pend_idx_r + 3'd1) == pend_cnt_r);
  assign in_tready  = pend_empty || last_pop;
  assign accept     = in_tvalid && in_tready;

  // matcher next state
  always_comb begin
    hold_nxt = hold_r;
    if (accept) begin
      if (in_tlast) begin
        hold_nxt = HOLD_NONE;
      end else begin
        case (hold_r)
          HOLD_E2: begin
            hold_nxt = (in_tdata == BYTE_80) ? HOLD_E2_80 : fresh_hold(in_tdata);
          end
          HOLD_E2_80: begin
            if (in_tdata inside {BYTE_LSQUO, BYTE_RSQUO, BYTE_LDQUO, BYTE_RDQUO,
                                 BYTE_NDASH, BYTE_MDASH, BYTE_HELLIP}) begin
              hold_nxt = HOLD_NONE;
            end else begin
              hold_nxt = fresh_hold(in_tdata);
            end
          end
          HOLD_C2: begin
            hold_nxt = (in_tdata == BYTE_NBSP) ? HOLD_NONE : fresh_hold(in_tdata);
          end
          default: hold_nxt = fresh_hold(in_tdata);
        endcase
      end
    end
  end

  // matcher outputs: bytes passed on to the word classifier
  always_comb begin
    fb    = '{default: '0};
    fcnt  = '0;
    fresh = 1'b1;
    case (hold_r)
      HOLD_E2: begin
        if (in_tdata == BYTE_80) begin
          fresh = 1'b0;
          if (in_tlast) begin
            fb[0] = BYTE_E2;
            fb[1] = BYTE_80;
            fcnt  = 2'd2;
          end
        end else begin
          fb[0] = BYTE_E2;
          fcnt  = 2'd1;
        end
      end
      HOLD_E2_80: begin
        if (in_tdata inside {BYTE_LSQUO, BYTE_RSQUO}) begin
          fresh = 1'b0;
          fb[0] = BYTE_APOS;
          fcnt  = 2'd1;
        end else if (in_tdata inside {BYTE_LDQUO, BYTE_RDQUO, BYTE_NDASH, BYTE_MDASH,
                                      BYTE_HELLIP}) begin
          fresh = 1'b0;
          fb[0] = BYTE_SPACE;
          fcnt  = 2'd1;
        end else begin
          fb[0] = BYTE_E2;
          fb[1] = BYTE_80;
          fcnt  = 2'd2;
        end
      end
      HOLD_C2: begin
        if (in_tdata == BYTE_NBSP) begin
          fresh = 1'b0;
          fb[0] = BYTE_SPACE;
          fcnt  = 2'd1;
        end else begin
          fb[0] = BYTE_C2;
          fcnt  = 2'd1;
        end
      end
      default: begin
      end
    endcase
    if (fresh) begin
      if ((in_tdata == BYTE_E2) || (in_tdata == BYTE_C2)) begin
        if (in_tlast) begin
          fb[fcnt] = in_tdata;
          fcnt     = fcnt + 2'd1;
        end
      end else begin
        fb[fcnt] = in_tdata;
        fcnt     = fcnt + 2'd1;
      end
    end
  end

  // classify passed bytes into append / flush events
  always_comb begin
    ev   = '{default: '0};
    ecnt = '0;
    st   = started_r;
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < fcnt) begin
        if (is_letter(fb[i]) || is_digit(fb[i]) || (is_joiner(fb[i]) && st)) begin
          ev[ecnt[1:0]] = '{data: fb[i], flush: 1'b0};
          ecnt          = ecnt + 3'd1;
          st            = 1'b1;
        end else if (st) begin
          ev[ecnt[1:0]] = '{data: '0, flush: 1'b1};
          ecnt          = ecnt + 3'd1;
          st            = 1'b0;
        end
      end
    end
    if (in_tlast && st) begin
      ev[ecnt[1:0]] = '{data: '0, flush: 1'b1};
      ecnt          = ecnt + 3'd1;
      st            = 1'b0;
    end
    started_nxt = accept ? st : started_r;
  end

  always_comb begin
    pend_cnt_nxt = pend_cnt_r;
    pend_idx_nxt = pend_idx_r;
    if (accept) begin
      pend_cnt_nxt = ecnt;
      pend_idx_nxt = '0;
    end else if (pop) begin
      pend_idx_nxt = pend_idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r     <= HOLD_NONE;
      started_r  <= 1'b0;
      pend_cnt_r <= '0;
      pend_idx_r <= '0;
    end else begin
      hold_r     <= hold_nxt;
      started_r  <= started_nxt;
      pend_cnt_r <= pend_cnt_nxt;
      pend_idx_r <= pend_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_r <= ev;
    end
  end

endmodule

>>> src/uws_fifo.sv
// Short event queue between front end and word builder
module uws_fifo import uws_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     s_valid,
  output logic     s_ready,
  input  uws_evt_t s_data,
  output logic     m_valid,
  input  logic     m_ready,
  output uws_evt_t m_data
);

  localparam int PTR_W = $clog2(EVT_FIFO_DEPTH);
  localparam int CNT_W = $clog2(EVT_FIFO_DEPTH + 1);

  uws_evt_t             slot_r [0:EVT_FIFO_DEPTH-1];
  logic [PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 push, take;

  assign s_ready = (count_r != CNT_W'(EVT_FIFO_DEPTH));
  assign m_valid = (count_r != '0);
  assign m_data  = slot_r[rd_ptr_r];
  assign push    = s_valid && s_ready;
  assign take    = m_valid && m_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(EVT_FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (take) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(EVT_FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !take) begin
      count_nxt = count_r + 1'b1;
    end else if (take && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= s_data;
    end
  end

endmodule

>>> src/uws_back.sv
// Back end: word builder with trim tracking, two-bank word store and byte emitter
`include "utf8_word_splitter_macros.svh"
module uws_back import uws_pkg::*; #(
  parameter int MAX_WORD_BYTES = MAX_WORD_BYTES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [MIN_CHARS_W-1:0] min_chars,
  input  logic                   evt_valid,
  output logic                   evt_ready,
  input  uws_evt_t               evt,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [7:0]             out_tdata,
  output logic                   out_tlast
);

  localparam int IDX_W     = $clog2(MAX_WORD_BYTES);
  localparam int LEN_W     = $clog2(MAX_WORD_BYTES + 1);
  localparam int MEM_DEPTH = 2 ** (IDX_W + 1);
  localparam int CMP_W     = ((LEN_W > MIN_CHARS_W) ? LEN_W : MIN_CHARS_W) + 1;

  logic [7:0] mem [0:MEM_DEPTH-1];

  // builder
  logic             wr_bank_r, wr_bank_nxt;
  logic [LEN_W-1:0] word_length_r, word_length_nxt;
  logic [LEN_W-1:0] char_starts_r, char_starts_nxt;
  logic             digit_seen_r, digit_seen_nxt;
  logic             too_long_r, too_long_nxt;
  logic [LEN_W-1:0] lnj_len_r, lnj_len_nxt;
  logic [LEN_W-1:0] lnj_prev_r, lnj_prev_nxt;
  logic             s_case_r, s_case_nxt;
  logic             prev_apos_r, prev_apos_nxt;

  // emitter
  logic             em_busy_r, em_busy_nxt;
  logic             em_bank_r, em_bank_nxt;
  logic [LEN_W-1:0] em_len_r, em_len_nxt;
  logic [LEN_W-1:0] em_idx_r, em_idx_nxt;
  logic             rd_valid_r, rd_valid_nxt;
  logic [7:0]       rd_data_r;
  logic             rd_last_r;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_data_r;
  logic             out_last_r;

  logic [LEN_W-1:0] final_len, chars;
  logic             worthy, append, store, flush_pop, handoff, rd_en, out_load;

  assign final_len = s_case_r ? lnj_prev_r : lnj_len_r;
  // trimmed bytes are ASCII, each one a character start
  assign chars     = char_starts_r - (word_length_r - final_len);
  assign worthy    = (final_len != '0) && !digit_seen_r && !too_long_r &&
                     (CMP_W'(chars) >= CMP_W'(min_chars));

  assign evt_ready = !evt.flush || !(worthy && em_busy_r);
  assign append    = evt_valid && !evt.flush;
  assign store     = append && (word_length_r < LEN_W'(MAX_WORD_BYTES));
  assign flush_pop = evt_valid && evt.flush && evt_ready;
  assign handoff   = flush_pop && worthy;

  always_comb begin
    wr_bank_nxt     = wr_bank_r;
    word_length_nxt = word_length_r;
    char_starts_nxt = char_starts_r;
    digit_seen_nxt  = digit_seen_r;
    too_long_nxt    = too_long_r;
    lnj_len_nxt     = lnj_len_r;
    lnj_prev_nxt    = lnj_prev_r;
    s_case_nxt      = s_case_r;
    prev_apos_nxt   = prev_apos_r;
    if (flush_pop) begin
      word_length_nxt = '0;
      char_starts_nxt = '0;
      digit_seen_nxt  = 1'b0;
      too_long_nxt    = 1'b0;
      lnj_len_nxt     = '0;
      lnj_prev_nxt    = '0;
      s_case_nxt      = 1'b0;
      prev_apos_nxt   = 1'b0;
      if (handoff) begin
        wr_bank_nxt = !wr_bank_r;
      end
    end else if (append) begin
      if (store) begin
        word_length_nxt = word_length_r + 1'b1;
        if ((evt.data & CONT_MASK) != CONT_CODE) begin
          char_starts_nxt = char_starts_r + 1'b1;
        end
        if (is_joiner(evt.data)) begin
          prev_apos_nxt = (evt.data == BYTE_APOS);
        end else begin
          lnj_prev_nxt  = lnj_len_r;
          lnj_len_nxt   = word_length_r + 1'b1;
          s_case_nxt    = ((evt.data == BYTE_LOW_S) || (evt.data == BYTE_UP_S)) && prev_apos_r;
          prev_apos_nxt = 1'b0;
        end
      end else begin
        too_long_nxt = 1'b1;
      end
      if (is_digit(evt.data)) begin
        digit_seen_nxt = 1'b1;
      end
    end
  end

  assign out_load = rd_valid_r && (!out_valid_r || out_tready);
  assign rd_en    = em_busy_r && (em_idx_r < em_len_r) && (!rd_valid_r || out_load);

  always_comb begin
    em_busy_nxt   = em_busy_r;
    em_bank_nxt   = em_bank_r;
    em_len_nxt    = em_len_r;
    em_idx_nxt    = em_idx_r;
    if (handoff) begin
      em_busy_nxt = 1'b1;
      em_bank_nxt = wr_bank_r;
      em_len_nxt  = final_len;
      em_idx_nxt  = '0;
    end else if (rd_en) begin
      em_idx_nxt = em_idx_r + 1'b1;
      if ((em_idx_r + 1'b1) == em_len_r) begin
        em_busy_nxt = 1'b0;
      end
    end
    rd_valid_nxt  = rd_en ? 1'b1 : (out_load ? 1'b0 : rd_valid_r);
    out_valid_nxt = out_load ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_bank_r     <= 1'b0;
      word_length_r <= '0;
      char_starts_r <= '0;
      digit_seen_r  <= 1'b0;
      too_long_r    <= 1'b0;
      lnj_len_r     <= '0;
      lnj_prev_r    <= '0;
      s_case_r      <= 1'b0;
      prev_apos_r   <= 1'b0;
      em_busy_r     <= 1'b0;
      em_bank_r     <= 1'b0;
      em_len_r      <= '0;
      em_idx_r      <= '0;
      rd_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      wr_bank_r     <= wr_bank_nxt;
      word_length_r <= word_length_nxt;
      char_starts_r <= char_starts_nxt;
      digit_seen_r  <= digit_seen_nxt;
      too_long_r    <= too_long_nxt;
      lnj_len_r     <= lnj_len_nxt;
      lnj_prev_r    <= lnj_prev_nxt;
      s_case_r      <= s_case_nxt;
      prev_apos_r   <= prev_apos_nxt;
      em_busy_r     <= em_busy_nxt;
      em_bank_r     <= em_bank_nxt;
      em_len_r      <= em_len_nxt;
      em_idx_r      <= em_idx_nxt;
      rd_valid_r    <= rd_valid_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (store) begin
      mem[{wr_bank_r, word_length_r[IDX_W-1:0]}] <= evt.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[{em_bank_r, em_idx_r[IDX_W-1:0]}];
      rd_last_r <= ((em_idx_r + 1'b1) == em_len_r);
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= rd_data_r;
      out_last_r <= rd_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

  `UWS_ASSERT_NOW(a_len_bound, 1'b1, word_length_r <= LEN_W'(MAX_WORD_BYTES), "word length over store size")
  `UWS_ASSERT_NOW(a_trim_bound, 1'b1, (lnj_prev_r <= lnj_len_r) && (lnj_len_r <= word_length_r), "trim point beyond word")
  `UWS_ASSERT_NOW(a_overflow_full, too_long_r, word_length_r == LEN_W'(MAX_WORD_BYTES), "overflow flagged before store full")
  `UWS_ASSERT_NOW(a_no_handoff_busy, handoff, !em_busy_r, "word handed to busy emitter")
  `UWS_ASSERT_NEXT(a_read_kept, rd_valid_r && out_valid_r && !out_tready, rd_valid_r, "read data lost under stall")

endmodule

>>> src/utf8_word_splitter.sv
// Top level of the UTF-8 word splitter: config register, front end, event queue, back end
//
//  channel   dir  beat contents
//  in_*      in   tdata = text_byte, tlast = end_of_text
//  out_*     out  tdata = word_byte, tlast = last_of_word
//  cfg_*     in   wdata = min_chars, written when cfg_wen is high
//
// The front end takes a new text byte once all word events of the previous byte are passed on;
// a byte that releases a held partial sequence or ends the text gives up to four word events.
// Word bytes leave one per cycle while out_tready is high; two-bank store, registered read.
// A kept word's end waits while the last word is being emitted; the event queue absorbs it.
// Reset is synchronous; no clearing pass, store entries are read only after being written.
module utf8_word_splitter import uws_pkg::*; #(
  parameter int MAX_WORD_BYTES = MAX_WORD_BYTES_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,   // [7:0] text_byte
  input  logic                   in_tlast,   // end_of_text
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [7:0]             out_tdata,  // [7:0] word_byte
  output logic                   out_tlast,  // last_of_word
  input  logic                   cfg_wen,
  input  logic [MIN_CHARS_W-1:0] cfg_wdata
);

  logic [MIN_CHARS_W-1:0] min_chars_r;
  logic                   fe_valid, fe_ready, be_valid, be_ready;
  uws_evt_t               fe_evt, be_evt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_chars_r <= MIN_CHARS_RST;
    end else if (cfg_wen) begin
      min_chars_r <= cfg_wdata;
    end
  end

  uws_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .evt_valid (fe_valid),
    .evt_ready (fe_ready),
    .evt       (fe_evt)
  );

  uws_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (fe_valid),
    .s_ready (fe_ready),
    .s_data  (fe_evt),
    .m_valid (be_valid),
    .m_ready (be_ready),
    .m_data  (be_evt)
  );

  uws_back #(
    .MAX_WORD_BYTES (MAX_WORD_BYTES)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .min_chars  (min_chars_r),
    .evt_valid  (be_valid),
    .evt_ready  (be_ready),
    .evt        (be_evt),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule
